>>> rtl/m3i_pkg.sv
// m3i_pkg: shared constants for the 3x3 matrix inverse block.
// Holds the output field widths and the cofactor index tables.
// No dependencies.
`default_nettype none
package m3i_pkg;

  localparam int NUM_ENTRIES    = 9;
  localparam int INV_BITS       = 32;
  localparam int DET_BITS       = 49;
  localparam int OUT_TDATA_BITS = ((NUM_ENTRIES * INV_BITS + DET_BITS + 7) / 8) * 8;

  typedef int unsigned idx_tbl_t [NUM_ENTRIES];

  // cofactor k = m[PA]*m[PB] - m[PC]*m[PD], entries indexed row*3+col
  localparam idx_tbl_t PA_IDX = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam idx_tbl_t PB_IDX = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam idx_tbl_t PC_IDX = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam idx_tbl_t PD_IDX = '{5, 1, 2, 3, 2, 0, 4, 0, 1};

endpackage
`default_nettype wire

>>> rtl/m3i_cofactor.sv
// m3i_cofactor: four-stage pipeline forming the nine cofactors and the
// determinant (first-row expansion). Depends on m3i_pkg.
`default_nettype none
module m3i_cofactor import m3i_pkg::*; #(
  parameter int EB = 16,
  parameter int CW = 33,
  parameter int DW = 49
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [EB-1:0] m   [NUM_ENTRIES],
  output logic signed [CW-1:0]      cof [NUM_ENTRIES],
  output logic signed [DW-1:0]      det
);

  localparam int PW = 2 * EB;

  logic signed [PW-1:0]    pa_r [NUM_ENTRIES];
  logic signed [PW-1:0]    pb_r [NUM_ENTRIES];
  logic signed [EB-1:0]    a0_r [3];
  logic signed [EB-1:0]    a1_r [3];
  logic signed [CW-1:0]    c2_r [NUM_ENTRIES];
  logic signed [CW-1:0]    c3_r [NUM_ENTRIES];
  logic signed [CW-1:0]    c4_r [NUM_ENTRIES];
  logic signed [EB+CW-1:0] dp_r [3];
  logic signed [DW-1:0]    det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: cross products
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        pa_r[k] <= m[PA_IDX[k]] * m[PB_IDX[k]];
        pb_r[k] <= m[PC_IDX[k]] * m[PD_IDX[k]];
      end
      for (int j = 0; j < 3; j++) begin
        a0_r[j] <= m[j];
        a1_r[j] <= a0_r[j];
      end
      // stage 2: cofactors, wrapping at CW bits
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        c2_r[k] <= CW'(pa_r[k]) - CW'(pb_r[k]);
        c3_r[k] <= c2_r[k];
        c4_r[k] <= c3_r[k];
      end
      // stage 3: first-row terms
      dp_r[0] <= a1_r[0] * c2_r[0];
      dp_r[1] <= a1_r[1] * c2_r[3];
      dp_r[2] <= a1_r[2] * c2_r[6];
      // stage 4: determinant
      det_r <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
    end
  end

  assign cof = c4_r;
  assign det = det_r;

endmodule
`default_nettype wire

>>> rtl/m3i_div_lane.sv
// m3i_div_lane: one divider lane, sign/magnitude prep then a restoring
// division stage per quotient bit, rounding and saturation at the end.
// Depends on m3i_pkg.
`default_nettype none
module m3i_div_lane import m3i_pkg::*; #(
  parameter int CW = 33,
  parameter int DW = 49,
  parameter int QS = 24
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [CW-1:0] cof,
  input  wire logic signed [DW-1:0] det,
  output logic [INV_BITS-1:0]       quo
);

  localparam int NW = (CW + QS > 64) ? 64 : CW + QS;

  logic [CW+QS-1:0] nfull;
  logic [CW-1:0]    cmag;

  logic [NW-1:0] num_r [NW+1];
  logic [DW-1:0] rem_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic          neg_r [NW+1];

  logic [NW:0]   q_rnd;
  logic          rnd_up;

  assign cmag  = cof[CW-1] ? (CW'(0) - cof) : cof;
  assign nfull = {cmag, {QS{1'b0}}};

  // prep stage
  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= nfull[NW-1:0];
      rem_r[0] <= '0;
      d_r[0]   <= det[DW-1] ? (DW'(0) - det) : det;
      neg_r[0] <= cof[CW-1] ^ det[DW-1];
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= NW; s++) begin : g_stage
    logic [DW:0] sh;
    logic        ge;
    logic [DW:0] dif;
    assign sh  = {rem_r[s-1], num_r[s-1][NW-1]};
    assign ge  = sh >= {1'b0, d_r[s-1]};
    assign dif = sh - {1'b0, d_r[s-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? dif[DW-1:0] : sh[DW-1:0];
        num_r[s] <= {num_r[s-1][NW-2:0], ge};
        d_r[s]   <= d_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  // round half away from zero, then saturate
  assign rnd_up = {rem_r[NW], 1'b0} >= {1'b0, d_r[NW]};
  assign q_rnd  = {1'b0, num_r[NW]} + (NW+1)'(rnd_up);

  always_comb begin
    if (!neg_r[NW]) begin
      quo = (q_rnd > (NW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_rnd[INV_BITS-1:0];
    end else begin
      quo = (q_rnd > (NW+1)'(33'h0_8000_0000)) ? 32'h8000_0000
          : (INV_BITS'(0) - q_rnd[INV_BITS-1:0]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/matrix3_inverse.sv
// matrix3_inverse: 3x3 matrix inverse by the adjugate, top level.
// Uses m3i_pkg, m3i_cofactor and nine m3i_div_lane instances.
//
// Usage:
//   The in_ channel carries one 3x3 matrix per word (nine signed entries
//   with ELEMENT_BITS/2 fraction bits). The out_ channel returns one word
//   per matrix: the nine inverse entries in signed Q16.16 (rounded, ties
//   away from zero, saturated), the determinant in 49 bits and, on tuser,
//   the nonsingular flag. A zero determinant gives all-zero data, flag 0.
//   A matrix passes the cofactor pipeline, the divider prep stage, the
//   restoring dividers (NW stages, one quotient bit a stage, where
//   NW = min(64, 2*ELEMENT_BITS+1 + ELEMENT_BITS/2 + 16)) and the output
//   register on its way to out_tvalid.
//   Throughput is one matrix per cycle while the receiver does not stall:
//   nine divider lanes run side by side and the output stage merges their
//   quotients with the determinant.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and in_tready drops in the same cycle; words are never lost.
//   Reset (rst_n low at a clock edge) empties the pipeline.
`default_nettype none
module matrix3_inverse import m3i_pkg::*; #(
  parameter int ELEMENT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
  input  wire logic [((NUM_ENTRIES*ELEMENT_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // inv00 .. inv22 (32 bits each) then determinant (49 bits), zero padded
  output logic [OUT_TDATA_BITS-1:0] out_tdata,
  // nonsingular
  output logic [0:0] out_tuser
);

  localparam int EB  = ELEMENT_BITS;
  localparam int CW  = (2*EB + 1 > 64) ? 64 : 2*EB + 1;
  localparam int DW  = (3*EB + 1 > 64) ? 64 : 3*EB + 1;
  localparam int QS  = EB/2 + 16;
  localparam int NW  = (CW + QS > 64) ? 64 : CW + QS;
  localparam int LAT = 4 + NW + 2;
  localparam int DLY = NW + 1;

  logic                 en;
  logic signed [EB-1:0] m   [NUM_ENTRIES];
  logic signed [CW-1:0] cof [NUM_ENTRIES];
  logic signed [DW-1:0] det;
  logic [INV_BITS-1:0]  quo [NUM_ENTRIES];

  logic [LAT-1:0]       vld_r;
  logic [DET_BITS-1:0]  det_r  [DLY];
  logic                 zero_r [DLY];
  logic [OUT_TDATA_BITS-1:0] data_r;
  logic                 nsg_r;

  // global advance: hold everything while an output word is stuck
  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_unpack
    assign m[i] = in_tdata[i*EB +: EB];
  end

  m3i_cofactor #(.EB(EB), .CW(CW), .DW(DW)) u_cof (
    .clk (clk),
    .en  (en),
    .m   (m),
    .cof (cof),
    .det (det)
  );

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_lane
    m3i_div_lane #(.CW(CW), .DW(DW), .QS(QS)) u_lane (
      .clk (clk),
      .en  (en),
      .cof (cof[i]),
      .det (det),
      .quo (quo[i])
    );
  end

  // valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // determinant delay line, matched to the divider lanes
  always_ff @(posedge clk) begin
    if (en) begin
      det_r[0]  <= DET_BITS'(det);
      zero_r[0] <= (det == '0);
      for (int j = 1; j < DLY; j++) begin
        det_r[j]  <= det_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
    end
  end

  // merge stage: output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        data_r[k*INV_BITS +: INV_BITS] <= zero_r[DLY-1] ? '0 : quo[k];
      end
      data_r[NUM_ENTRIES*INV_BITS +: DET_BITS] <= zero_r[DLY-1] ? '0 : det_r[DLY-1];
      data_r[OUT_TDATA_BITS-1:NUM_ENTRIES*INV_BITS+DET_BITS] <= '0;
      nsg_r <= !zero_r[DLY-1];
    end
  end

  assign out_tvalid   = vld_r[LAT-1];
  assign out_tdata    = data_r;
  assign out_tuser[0] = nsg_r;

endmodule
`default_nettype wire

>>> dv/matrix3_inverse_tb.sv
// matrix3_inverse_tb: self-checking bench for the 3x3 adjugate inverse block.
// Drives matrices on the in_ stream, predicts each inverse word and checks out_.
// Depends on m3i_pkg and the matrix3_inverse RTL.
`default_nettype none
module matrix3_inverse_tb;
  import m3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EB      = 16;
  localparam int IN_BITS = ((NUM_ENTRIES * EB + 7) / 8) * 8;
  localparam int LATENCY = 62;
  localparam int LIMIT   = 400000;

  typedef logic signed [EB-1:0] elem_t;
  typedef struct {
    logic [INV_BITS-1:0] inv [NUM_ENTRIES];
    logic [DET_BITS-1:0] det;
    logic                nonsingular;
  } inv_word_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Rounded, saturated cof * 2^24 / det (det nonzero).
  function automatic logic [INV_BITS-1:0] divide_entry(logic signed [63:0] cof,
                                                       logic signed [63:0] det);
    logic        neg;
    logic [63:0] n, d, q;
    neg = cof[63] ^ det[63];
    n = (cof[63] ? -cof : cof) << (EB / 2 + 16);
    d = det[63] ? -det : det;
    q = n / d;
    if ((n % d) >= d - d / 2) q++;
    if (!neg) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return -q[31:0];
  endfunction

  function automatic inv_word_t invert_matrix(logic [IN_BITS-1:0] w);
    logic signed [63:0] a [NUM_ENTRIES];
    logic signed [63:0] cof [NUM_ENTRIES];
    logic signed [63:0] det;
    inv_word_t r;
    for (int i = 0; i < NUM_ENTRIES; i++) a[i] = elem_t'(w[i*EB +: EB]);
    cof[0] = a[4]*a[8] - a[7]*a[5];
    cof[1] = a[2]*a[7] - a[8]*a[1];
    cof[2] = a[1]*a[5] - a[4]*a[2];
    cof[3] = a[5]*a[6] - a[8]*a[3];
    cof[4] = a[0]*a[8] - a[6]*a[2];
    cof[5] = a[2]*a[3] - a[5]*a[0];
    cof[6] = a[3]*a[7] - a[6]*a[4];
    cof[7] = a[1]*a[6] - a[7]*a[0];
    cof[8] = a[0]*a[4] - a[3]*a[1];
    det = a[0]*cof[0] + a[1]*cof[3] + a[2]*cof[6];
    r.nonsingular = (det != 0);
    r.det = det[DET_BITS-1:0];
    for (int k = 0; k < NUM_ENTRIES; k++)
      r.inv[k] = (det == 0) ? '0 : divide_entry(cof[k], det);
    return r;
  endfunction

  class inverse_scoreboard;
    inv_word_t pending [$];
    task note_matrix(logic [IN_BITS-1:0] w);
      pending.push_back(invert_matrix(w));
    endtask
    task check_word(logic [OUT_TDATA_BITS-1:0] d, logic flag);
      inv_word_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", d[63:0], 0);
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < NUM_ENTRIES; k++)
        if (d[k*INV_BITS +: INV_BITS] !== e.inv[k])
          report_mismatch($sformatf("inv%0d", k), d[k*INV_BITS +: INV_BITS], e.inv[k]);
      if (d[NUM_ENTRIES*INV_BITS +: DET_BITS] !== e.det)
        report_mismatch("determinant", d[NUM_ENTRIES*INV_BITS +: DET_BITS], e.det);
      if (flag !== e.nonsingular) report_mismatch("nonsingular", flag, e.nonsingular);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [IN_BITS-1:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic [0:0] out_tuser;

  matrix3_inverse #(.ELEMENT_BITS(EB)) dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  inverse_scoreboard sb = new();
  int in_idle_pct = 32, out_idle_pct = 73;
  int hold_cycles = 0;
  int cycles = 0;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("matrix3_inverse_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off when requested
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser[0]);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(1024)) - 512);
      default: return elem_t'($urandom_range(3) == 0 ? 16'h8000 :
                              ($urandom_range(1) ? 16'h7FFF : 16'h0000));
    endcase
  endfunction

  // send one matrix word, holding valid until accepted
  task automatic send_matrix(input logic [IN_BITS-1:0] w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_matrix(w);
  endtask

  function automatic logic [IN_BITS-1:0] pack(elem_t e [NUM_ENTRIES]);
    logic [IN_BITS-1:0] w = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) w[i*EB +: EB] = e[i];
    return w;
  endfunction

  function automatic logic [IN_BITS-1:0] random_matrix();
    elem_t e [NUM_ENTRIES];
    int mode, kind;
    mode = $urandom_range(2);
    kind = $urandom_range(9);
    for (int i = 0; i < NUM_ENTRIES; i++) e[i] = rand_elem(mode);
    // copy a row (singular), or a small diagonal (tiny or zero det)
    if (kind == 0) for (int c = 0; c < 3; c++) e[6+c] = e[c];
    if (kind == 1) for (int i = 0; i < NUM_ENTRIES; i++)
      e[i] = (i % 4 == 0) ? elem_t'($urandom_range(3)) : elem_t'(0);
    return pack(e);
  endfunction

  initial begin
    elem_t e [NUM_ENTRIES];
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: identity, zero, extremes, tiny and scaled diagonals
    for (int t = 0; t < 12; t++) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        case (t)
          0: e[i] = (i % 4 == 0) ? elem_t'(16'h0100) : elem_t'(0);
          1: e[i] = 0;
          2: e[i] = elem_t'(16'h7FFF);
          3: e[i] = elem_t'(16'h8000);
          4: e[i] = (i % 4 == 0) ? elem_t'(16'h8000) : elem_t'(0);
          5: e[i] = (i % 4 == 0) ? elem_t'(16'h7FFF) : elem_t'(0);
          6: e[i] = (i % 4 == 0) ? elem_t'(1) : elem_t'(0);
          7: e[i] = (i % 4 == 0) ? elem_t'(-1) : elem_t'(0);
          8: e[i] = (i % 4 == 0) ? elem_t'(3) : elem_t'(0);
          9: e[i] = (i % 4 == 0) ? elem_t'(16'h8000) : elem_t'(16'h7FFF);
          10: e[i] = elem_t'(i * 16'h0100 + 16'h0100);
          default: e[i] = (i % 4 == 0) ? elem_t'(16'h0300) : elem_t'(16'h0080);
        endcase
      end
      send_matrix(pack(e));
    end

    // random phases with changing idle mix, long receiver hold-off in phase 2
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        in_idle_pct = 73;
        out_idle_pct = 32;
      end
      if (ph == 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      for (int n = 0; n < 515; n++) begin
        if (n == 100 && ph == 2) hold_cycles = 300;
        if (n == 60 && ph == 0) begin
          in_idle_pct = 0;
          repeat (40) send_matrix(random_matrix());
          in_idle_pct = 32;
        end
        send_matrix(random_matrix());
      end
    end
    in_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("matrix3_inverse_tb: PASS");
    else $display("matrix3_inverse_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
